@@ rtl/hv_pkg.sv @@
// hostname validator package: per-hostname state record and utf-8 limit codes
// shared by the byte check logic and the top level, no dependencies
`default_nettype none

package hv_pkg;

  localparam int unsigned TotalW = 8;
  localparam int unsigned LabelW = 7;
  localparam int unsigned PendW  = 2;

  localparam logic [7:0] CharDot    = 8'h2e;
  localparam logic [7:0] CharHyphen = 8'h2d;
  localparam logic [7:0] HighByte   = 8'h80;

  typedef enum logic [2:0] {
    LIM_ANY   = 3'd0,
    LIM_A0_BF = 3'd1,
    LIM_80_9F = 3'd2,
    LIM_90_BF = 3'd3,
    LIM_80_8F = 3'd4
  } lim_e;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic [LabelW-1:0] label;
    logic              hyphen;
    logic [PendW-1:0]  pend;
    lim_e              lim;
    logic              failed;
  } st_t;

  localparam st_t StClear = '{
    total:  '0,
    label:  '0,
    hyphen: 1'b0,
    pend:   '0,
    lim:    LIM_ANY,
    failed: 1'b0
  };

endpackage

`default_nettype wire

@@ rtl/hv_byte_check.sv @@
// hostname validator byte check: next state and verdict for one byte
// depends on hv_pkg
`default_nettype none

module hv_byte_check import hv_pkg::*; #(
  parameter int unsigned MAX_HOST_BYTES  = 253,
  parameter int unsigned MAX_LABEL_BYTES = 63
) (
  input  st_t        st_i,
  input  logic [7:0] byte_i,
  input  logic       utf8_en_i,
  output st_t        st_o,
  output logic       ok_o
);

  localparam logic [TotalW-1:0] TotMax = TotalW'(MAX_HOST_BYTES);
  localparam logic [LabelW-1:0] LabMax = LabelW'(MAX_LABEL_BYTES);

  logic [LabelW-1:0] lab_inc;
  logic              cont_ok;
  logic              alnum;
  logic              dot_end;
  st_t               s;

  always_comb begin
    lab_inc = (st_i.label != '1) ? st_i.label + LabelW'(1) : st_i.label;
    alnum = (byte_i >= 8'h30 && byte_i <= 8'h39) ||
            (byte_i >= 8'h41 && byte_i <= 8'h5a) ||
            (byte_i >= 8'h61 && byte_i <= 8'h7a);
    case (st_i.lim)
      LIM_A0_BF: cont_ok = byte_i >= 8'ha0 && byte_i <= 8'hbf;
      LIM_80_9F: cont_ok = byte_i >= 8'h80 && byte_i <= 8'h9f;
      LIM_90_BF: cont_ok = byte_i >= 8'h90 && byte_i <= 8'hbf;
      LIM_80_8F: cont_ok = byte_i >= 8'h80 && byte_i <= 8'h8f;
      default:   cont_ok = byte_i >= 8'h80 && byte_i <= 8'hbf;
    endcase
  end

  always_comb begin
    s = st_i;
    dot_end = 1'b0;
    s.total = (st_i.total != '1) ? st_i.total + TotalW'(1) : st_i.total;
    if (s.total > TotMax) begin
      s.failed = 1'b1;
    end
    if (!s.failed) begin
      if (st_i.pend != '0) begin
        if (!cont_ok) begin
          s.failed = 1'b1;
        end else begin
          s.pend  = st_i.pend - PendW'(1);
          s.lim   = LIM_ANY;
          s.label = lab_inc;
          if (lab_inc > LabMax) s.failed = 1'b1;
        end
      end else if (byte_i == CharDot) begin
        if (st_i.label == '0 || st_i.hyphen) s.failed = 1'b1;
        s.label  = '0;
        s.hyphen = 1'b0;
        dot_end  = 1'b1;
      end else if (byte_i < HighByte) begin
        if (alnum || (byte_i == CharHyphen && st_i.label != '0)) begin
          s.hyphen = !alnum;
          s.label  = lab_inc;
          if (lab_inc > LabMax) s.failed = 1'b1;
        end else begin
          s.failed = 1'b1;
        end
      end else begin
        if (!utf8_en_i) begin
          s.failed = 1'b1;
        end else if (byte_i >= 8'hc2 && byte_i <= 8'hdf) begin
          s.pend = PendW'(1);
          s.lim  = LIM_ANY;
        end else if (byte_i == 8'he0) begin
          s.pend = PendW'(2);
          s.lim  = LIM_A0_BF;
        end else if (byte_i == 8'hed) begin
          s.pend = PendW'(2);
          s.lim  = LIM_80_9F;
        end else if (byte_i >= 8'he1 && byte_i <= 8'hef) begin
          s.pend = PendW'(2);
          s.lim  = LIM_ANY;
        end else if (byte_i == 8'hf0) begin
          s.pend = PendW'(3);
          s.lim  = LIM_90_BF;
        end else if (byte_i == 8'hf4) begin
          s.pend = PendW'(3);
          s.lim  = LIM_80_8F;
        end else if (byte_i >= 8'hf1 && byte_i <= 8'hf3) begin
          s.pend = PendW'(3);
          s.lim  = LIM_ANY;
        end else begin
          s.failed = 1'b1;
        end
        if (!s.failed) begin
          s.hyphen = 1'b0;
          s.label  = lab_inc;
          if (lab_inc > LabMax) s.failed = 1'b1;
        end
      end
    end
    st_o = s;
    ok_o = !s.failed && s.pend == '0 && (dot_end || (s.label != '0 && !s.hyphen));
  end

endmodule

`default_nettype wire

@@ rtl/hostname_validator_unit.sv @@
// hostname validator top level: running hostname state, config register, result register
// depends on hv_pkg and hv_byte_check
// the verdict is registered and shows on the master side in the cycle after the final beat is accepted
// throughput: one byte per cycle while the master side takes results
// a result waiting in the output register is held until taken; bytes other than a final beat keep flowing meanwhile
// reset: all state, the utf-8 enable and the output register clear asynchronously
`default_nettype none

module hostname_validator_unit import hv_pkg::*; #(
  parameter int unsigned MAX_HOST_BYTES  = 253,
  parameter int unsigned MAX_LABEL_BYTES = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,   // utf-8 enable
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] byte_value
  input  logic       s_axis_tlast,
  input  logic       s_axis_tuser,  // [0] empty_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] valid_res, [7:1] zero
);

  st_t  st_q, st_d, st_chk;
  logic utf8_q;
  logic ovld_q, ovld_d;
  logic ores_q, ores_d;
  logic chk_ok;
  logic acc;
  logic ends;
  logic room;

  hv_byte_check #(
    .MAX_HOST_BYTES (MAX_HOST_BYTES),
    .MAX_LABEL_BYTES(MAX_LABEL_BYTES)
  ) u_check (
    .st_i     (st_q),
    .byte_i   (s_axis_tdata),
    .utf8_en_i(utf8_q),
    .st_o     (st_chk),
    .ok_o     (chk_ok)
  );

  // only final beats need a free output slot
  assign room          = !ovld_q || m_axis_tready;
  assign ends          = s_axis_tlast || s_axis_tuser;
  assign s_axis_tready = room || !ends;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    st_d   = st_q;
    ovld_d = ovld_q && !m_axis_tready;
    ores_d = ores_q;
    if (acc) begin
      if (ends) begin
        st_d   = StClear;
        ovld_d = 1'b1;
        ores_d = !s_axis_tuser && chk_ok;
      end else begin
        st_d = st_chk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StClear;
      utf8_q <= 1'b0;
      ovld_q <= 1'b0;
      ores_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ovld_q <= ovld_d;
      ores_q <= ores_d;
      if (cfg_we_i) utf8_q <= cfg_wdata_i;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {7'b0, ores_q};

endmodule

`default_nettype wire

@@ rtl/hv_checker.sv @@
// hostname validator port checker and its bind to the top level
// depends on hostname_validator_unit ports only
`default_nettype none

module hv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // empty string beat gives an invalid verdict next cycle
  a_empty_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("empty string did not yield an invalid verdict");

  // a final beat always yields a verdict next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tlast |=> m_axis_tvalid)
    else $error("final beat produced no verdict");

  // an inner beat with the output slot free creates no verdict
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) && acc && !s_axis_tlast && !s_axis_tuser
    |=> !m_axis_tvalid)
    else $error("verdict without a final beat");

  // hostname ending in a hyphen is never valid
  a_hyphen_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tlast && !s_axis_tuser && s_axis_tdata == 8'h2d
    |=> !m_axis_tdata[0])
    else $error("hostname ending in hyphen reported valid");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled verdict changed");

endmodule

bind hostname_validator_unit hv_checker u_hv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tlast (s_axis_tlast),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
